// File: src/iso_date_text_parser_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ISO date text parser
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ISO_DATE_TEXT_PARSER_DEFINES_SVH
`define ISO_DATE_TEXT_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IDP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("idp assertion failed");

// Next-cycle implication, disabled during reset.
`define IDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("idp assertion failed");

`endif

// File: src/idp_pkg.sv
// ----------------------------------------------------------------------------
// idp_pkg
// Types, constants and helper functions of the ISO date text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package idp_pkg;

   localparam int YearWidth     = 14;
   localparam int AccumWidth    = 7;
   localparam int MonthWidth    = 4;
   localparam int DayWidth      = 5;
   localparam int PosWidth      = 4;
   localparam int CsrIndexWidth = 1;

   localparam logic [7:0] CharDash = 8'h2D;
   localparam logic [7:0] CharZero = 8'h30;
   localparam logic [7:0] CharNine = 8'h39;

   localparam logic [PosWidth-1:0] PosDash1 = 4'd4;
   localparam logic [PosWidth-1:0] PosDash2 = 4'd7;
   localparam logic [PosWidth-1:0] TextLen  = 4'd10;
   localparam logic [PosWidth-1:0] PosSat   = 4'd11;

   localparam logic [YearWidth-1:0] MinYearReset = 14'd1900;
   localparam logic [YearWidth-1:0] MaxYearReset = 14'd9999;

   localparam logic [CsrIndexWidth-1:0] CSR_MIN_YEAR = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_YEAR = 1'b1;

   localparam logic [DayWidth-1:0] MonthLen [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };
   localparam logic [DayWidth-1:0] LeapFebDays = 5'd29;

   // Snapshot of a finished text, passed from the scanner to the checker.
   typedef struct packed {
      logic                  empty_text;
      logic                  shape_ok;
      logic                  leap;
      logic [YearWidth-1:0]  year;
      logic [AccumWidth-1:0] month;
      logic [AccumWidth-1:0] day;
   } snap_type;

   typedef struct packed {
      logic                  date_ok;
      logic                  is_no_date;
      logic [YearWidth-1:0]  year_value;
      logic [MonthWidth-1:0] month_value;
      logic [DayWidth-1:0]   day_value;
   } result_type;

   function automatic logic [YearWidth-1:0] year_shift_in(
      input logic [YearWidth-1:0] acc,
      input logic [3:0]           digit
   );
      logic [YearWidth+3:0] wide;
      begin
         wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{YearWidth{1'b0}}, digit};
         return wide[YearWidth-1:0];
      end
   endfunction

   function automatic logic [AccumWidth-1:0] small_shift_in(
      input logic [AccumWidth-1:0] acc,
      input logic [3:0]            digit
   );
      logic [AccumWidth+3:0] wide;
      begin
         wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{AccumWidth{1'b0}}, digit};
         return wide[AccumWidth-1:0];
      end
   endfunction

   // Days in a month; zero for a month outside 1 to 12.
   function automatic logic [DayWidth-1:0] month_days(
      input logic [MonthWidth-1:0] month,
      input logic                  leap
   );
      logic [MonthWidth-1:0] idx;
      begin
         idx = month - 4'd1;
         if (month == 4'd0 || month > 4'd12) begin
            return '0;
         end else if (month == 4'd2 && leap) begin
            return LeapFebDays;
         end else begin
            return MonthLen[idx];
         end
      end
   endfunction

endpackage

`default_nettype wire

// File: src/idp_channels.sv
// ----------------------------------------------------------------------------
// idp_req_if / idp_rsp_if
// Valid/ready channels carrying text characters in and parsed dates out.
// ----------------------------------------------------------------------------
`default_nettype none

interface idp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       char_present;
   logic       end_of_text;

   modport source (output valid, output text_char, output char_present,
                   output end_of_text, input ready);
   modport sink   (input valid, input text_char, input char_present,
                   input end_of_text, output ready);
endinterface

interface idp_rsp_if;
   logic        valid;
   logic        ready;
   logic        date_ok;
   logic        is_no_date;
   logic [13:0] year_value;
   logic [3:0]  month_value;
   logic [4:0]  day_value;

   modport source (output valid, output date_ok, output is_no_date,
                   output year_value, output month_value, output day_value,
                   input ready);
   modport sink   (input valid, input date_ok, input is_no_date,
                   input year_value, input month_value, input day_value,
                   output ready);
endinterface

`default_nettype wire

// File: src/idp_scanner.sv
// ----------------------------------------------------------------------------
// idp_scanner
// Tracks position and digit accumulators per character; snapshots the text.
// ----------------------------------------------------------------------------
`default_nettype none

module idp_scanner (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire logic [7:0]        text_char,
   input  wire logic              char_present,
   input  wire logic              end_of_text,
   output      logic              snap_valid,
   input  wire logic              snap_ready,
   output      idp_pkg::snap_type snap
);
   import idp_pkg::*;

   logic [PosWidth-1:0]   pos_ff, pos_in;
   logic [YearWidth-1:0]  year_ff, year_in;
   logic [AccumWidth-1:0] month_ff, month_in;
   logic [AccumWidth-1:0] day_ff, day_in;
   logic                  err_ff, err_in;
   // Year digits mod 4, pairwise: 10 is 2 mod 4, so a pair folds as 2*hi + lo.
   logic [1:0]            pair_mod4_ff, pair_mod4_in;
   logic [1:0]            hi_mod4_ff, hi_mod4_in;
   logic [1:0]            lo_mod4_ff, lo_mod4_in;
   logic                  lo_zero_ff, lo_zero_in;
   logic                  snap_valid_ff, snap_valid_in;
   snap_type              snap_ff, snap_in;

   logic       accept;
   logic       is_digit;
   logic [3:0] digit;
   logic [1:0] pair_fold;

   assign in_ready   = !snap_valid_ff || snap_ready;
   assign accept     = in_valid && in_ready;
   assign is_digit   = (text_char >= CharZero) && (text_char <= CharNine);
   assign digit      = text_char[3:0];
   assign pair_fold  = {pair_mod4_ff[0], 1'b0} + digit[1:0];
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   always_comb begin
      pos_in        = pos_ff;
      year_in       = year_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      err_in        = err_ff;
      pair_mod4_in  = pair_mod4_ff;
      hi_mod4_in    = hi_mod4_ff;
      lo_mod4_in    = lo_mod4_ff;
      lo_zero_in    = lo_zero_ff;
      snap_valid_in = snap_valid_ff && !snap_ready;
      snap_in       = snap_ff;

      if (accept && char_present) begin
         if (pos_ff < TextLen && !err_ff) begin
            if (pos_ff == PosDash1 || pos_ff == PosDash2) begin
               if (text_char != CharDash) begin
                  err_in = 1'b1;
               end
            end else if (!is_digit) begin
               err_in = 1'b1;
            end else if (pos_ff < PosDash1) begin
               year_in = year_shift_in(year_ff, digit);
               if (pos_ff == 4'd0 || pos_ff == 4'd2) begin
                  pair_mod4_in = digit[1:0];
               end
               if (pos_ff == 4'd1) begin
                  hi_mod4_in = pair_fold;
               end
               if (pos_ff == 4'd2) begin
                  lo_zero_in = (digit == 4'd0);
               end
               if (pos_ff == 4'd3) begin
                  lo_mod4_in = pair_fold;
                  lo_zero_in = lo_zero_ff && (digit == 4'd0);
               end
            end else if (pos_ff < PosDash2) begin
               month_in = small_shift_in(month_ff, digit);
            end else begin
               day_in = small_shift_in(day_ff, digit);
            end
         end
         if (pos_ff < PosSat) begin
            pos_in = pos_ff + 4'd1;
         end
      end

      if (accept && end_of_text) begin
         snap_valid_in      = 1'b1;
         snap_in.empty_text = (pos_in == 4'd0);
         snap_in.shape_ok   = (pos_in == TextLen) && !err_in;
         snap_in.leap       = lo_zero_in ? (hi_mod4_in == 2'd0) : (lo_mod4_in == 2'd0);
         snap_in.year       = year_in;
         snap_in.month      = month_in;
         snap_in.day        = day_in;
         // The text is finished, so parsing starts over.
         pos_in       = '0;
         year_in      = '0;
         month_in     = '0;
         day_in       = '0;
         err_in       = 1'b0;
         pair_mod4_in = '0;
         hi_mod4_in   = '0;
         lo_mod4_in   = '0;
         lo_zero_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         year_ff       <= '0;
         month_ff      <= '0;
         day_ff        <= '0;
         err_ff        <= 1'b0;
         pair_mod4_ff  <= '0;
         hi_mod4_ff    <= '0;
         lo_mod4_ff    <= '0;
         lo_zero_ff    <= 1'b0;
         snap_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         year_ff       <= year_in;
         month_ff      <= month_in;
         day_ff        <= day_in;
         err_ff        <= err_in;
         pair_mod4_ff  <= pair_mod4_in;
         hi_mod4_ff    <= hi_mod4_in;
         lo_mod4_ff    <= lo_mod4_in;
         lo_zero_ff    <= lo_zero_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

endmodule

`default_nettype wire

// File: src/idp_validate.sv
// ----------------------------------------------------------------------------
// idp_validate
// Year bound registers, calendar checks and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module idp_validate (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [idp_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [idp_pkg::YearWidth-1:0]        csr_wdata,
   input  wire logic                                 snap_valid,
   output      logic                                 snap_ready,
   input  wire idp_pkg::snap_type                    snap,
   output      logic                                 out_valid,
   input  wire logic                                 out_ready,
   output      idp_pkg::result_type                  result
);
   import idp_pkg::*;

   logic [YearWidth-1:0] min_year_ff, min_year_in;
   logic [YearWidth-1:0] max_year_ff, max_year_in;
   logic                 out_valid_ff, out_valid_in;
   result_type           result_ff, result_in;

   logic                 load;
   logic                 all_zero;
   logic                 month_ok;
   logic [DayWidth-1:0]  days;
   logic                 real_ok;

   assign snap_ready = !out_valid_ff || out_ready;
   assign load       = snap_valid && snap_ready;
   assign out_valid  = out_valid_ff;
   assign result     = result_ff;

   always_comb begin
      min_year_in = min_year_ff;
      max_year_in = max_year_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MIN_YEAR: min_year_in = csr_wdata;
            CSR_MAX_YEAR: max_year_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign all_zero = (snap.year == '0) && (snap.month == '0) && (snap.day == '0);
   assign month_ok = (snap.month >= 7'd1) && (snap.month <= 7'd12);
   assign days     = month_days(snap.month[MonthWidth-1:0], snap.leap);
   assign real_ok  = (snap.year >= min_year_ff) && (snap.year <= max_year_ff) && month_ok
                     && (snap.day >= 7'd1) && (snap.day <= {2'b0, days});

   always_comb begin
      out_valid_in = out_valid_ff && !out_ready;
      result_in    = result_ff;
      if (load) begin
         out_valid_in = 1'b1;
         result_in    = '0;
         if (snap.empty_text || (snap.shape_ok && all_zero)) begin
            result_in.date_ok    = 1'b1;
            result_in.is_no_date = 1'b1;
         end else if (snap.shape_ok && real_ok) begin
            result_in.date_ok     = 1'b1;
            result_in.year_value  = snap.year;
            result_in.month_value = snap.month[MonthWidth-1:0];
            result_in.day_value   = snap.day[DayWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_year_ff  <= MinYearReset;
         max_year_ff  <= MaxYearReset;
         out_valid_ff <= 1'b0;
      end else begin
         min_year_ff  <= min_year_in;
         max_year_ff  <= max_year_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule

`default_nettype wire

// File: src/iso_date_text_parser.sv
// ----------------------------------------------------------------------------
// iso_date_text_parser: strict YYYY-MM-DD parser, one character per transfer.
// Throughput: one character transfer per cycle, unless a full snapshot register stalls input.
// A finished text's result passes the scanner snapshot register, then the validator result register.
// Reset (synchronous): clears parse state, bounds return to 1900 and 9999.
// ----------------------------------------------------------------------------
`default_nettype none

module iso_date_text_parser (
   input  wire logic                              clock,
   input  wire logic                              reset,
   idp_req_if.sink                                req_ch,
   idp_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [idp_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [idp_pkg::YearWidth-1:0]     csr_wdata
);
   import idp_pkg::*;

   logic       snap_valid;
   logic       snap_ready;
   snap_type   snap;
   result_type result;
   logic       in_ready;
   logic       out_valid;

   idp_scanner u_scanner (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_ch.valid),
      .in_ready     (in_ready),
      .text_char    (req_ch.text_char),
      .char_present (req_ch.char_present),
      .end_of_text  (req_ch.end_of_text),
      .snap_valid   (snap_valid),
      .snap_ready   (snap_ready),
      .snap         (snap)
   );

   idp_validate u_validate (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .out_valid  (out_valid),
      .out_ready  (rsp_ch.ready),
      .result     (result)
   );

   assign req_ch.ready       = in_ready;
   assign rsp_ch.valid       = out_valid;
   assign rsp_ch.date_ok     = result.date_ok;
   assign rsp_ch.is_no_date  = result.is_no_date;
   assign rsp_ch.year_value  = result.year_value;
   assign rsp_ch.month_value = result.month_value;
   assign rsp_ch.day_value   = result.day_value;

endmodule

`default_nettype wire

// File: src/iso_date_text_parser_props.sv
// ----------------------------------------------------------------------------
// iso_date_text_parser_props
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "iso_date_text_parser_defines.svh"

module iso_date_text_parser_props (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_date_ok,
   input wire logic        rsp_is_no_date,
   input wire logic [13:0] rsp_year_value,
   input wire logic [3:0]  rsp_month_value,
   input wire logic [4:0]  rsp_day_value
);

   `IDP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_date_ok) && $stable(rsp_is_no_date)
      && $stable(rsp_year_value) && $stable(rsp_month_value) && $stable(rsp_day_value))

   `IDP_ASSERT_IMPLY(a_reject_zero, clock, reset, rsp_valid && !rsp_date_ok,
      !rsp_is_no_date && rsp_year_value == 14'd0 && rsp_month_value == 4'd0
      && rsp_day_value == 5'd0)

   `IDP_ASSERT_IMPLY(a_no_date_zero, clock, reset, rsp_valid && rsp_is_no_date,
      rsp_date_ok && rsp_year_value == 14'd0 && rsp_month_value == 4'd0
      && rsp_day_value == 5'd0)

   `IDP_ASSERT_IMPLY(a_real_date_range, clock, reset,
      rsp_valid && rsp_date_ok && !rsp_is_no_date,
      rsp_month_value >= 4'd1 && rsp_month_value <= 4'd12 && rsp_day_value >= 5'd1
      && rsp_year_value <= 14'd9999)

endmodule

bind iso_date_text_parser iso_date_text_parser_props u_props (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_date_ok     (rsp_ch.date_ok),
   .rsp_is_no_date  (rsp_ch.is_no_date),
   .rsp_year_value  (rsp_ch.year_value),
   .rsp_month_value (rsp_ch.month_value),
   .rsp_day_value   (rsp_ch.day_value)
);

`default_nettype wire
